// ===== hdl/mrc_pkg.sv =====
// shared types, constants and the helper function of the region counter
`default_nettype none

package mrc_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned STATE_W     = 64;
  localparam int unsigned STREAM_W    = 63;
  localparam int unsigned COUNT_W     = 40;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned PIPE_DEPTH  = 7;

  // pcg32 multiplier split into 32-bit halves
  localparam logic [WORD_W-1:0] MULT_LO = 32'h4C95_7F2D;
  localparam logic [WORD_W-1:0] MULT_HI = 32'h5851_F42D;

  // register defaults
  localparam logic [STATE_W-1:0]  SEED_RST     = 64'd42;
  localparam logic [STREAM_W-1:0] X_STREAM_RST = 63'd430;
  localparam logic [STREAM_W-1:0] Y_STREAM_RST = 63'd431;
  localparam logic [WORD_W-1:0]   RADIUS_RST   = 32'd0;
  localparam logic [COUNT_W-1:0]  SAMPLES_RST  = 40'd1;

  // generator pre-state (seed plus increment) for the default registers
  localparam logic [STATE_W-1:0] X_PRE_RST = SEED_RST + {X_STREAM_RST, 1'b1};
  localparam logic [STATE_W-1:0] Y_PRE_RST = SEED_RST + {Y_STREAM_RST, 1'b1};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RNG_SEED     = 3'd0,
    REG_X_STREAM     = 3'd1,
    REG_Y_STREAM     = 3'd2,
    REG_RADIUS       = 3'd3,
    REG_SAMPLE_COUNT = 3'd4
  } cfg_reg_t;

  // flags that travel with each word down the pipeline
  typedef struct packed {
    logic restart;
    logic take;
    logic done;
  } step_flags_t;

  // generator stage control
  typedef struct packed {
    logic adv_lo;
    logic restart_lo;
    logic take_lo;
    logic adv_hi;
    logic restart_hi;
    logic take_hi;
    logic adv_out;
  } pcg_ctl_t;

  // geometry stage control
  typedef struct packed {
    logic adv_prep;
    logic adv_sq;
    logic adv_cmp;
  } geo_ctl_t;

  // pcg32 xsh-rr output permutation of a generator state
  function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] mixed;
    logic [WORD_W-1:0]  sh;
    logic [4:0]         rot;
    logic [4:0]         lrot;
    mixed = s ^ (s >> 18);
    sh    = mixed[58:27];
    rot   = s[63:59];
    lrot  = ~rot + 5'd1;
    return (sh >> rot) | (sh << lrot);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/monte_carlo_region_counter.sv =====
// pipeline: flag, low-half, high-half, permutation, offset, square and compare stages,
//   then the output register; one input word per cycle unless in_stall is raised;
//   each generator's low half takes two 32x32 multiplies, its high half one a stage later
// reset: synchronous; clears pipeline, counters and output, restores register defaults
//   and loads both generators with the state seeded from the default seed and streams
`default_nettype none

module monte_carlo_region_counter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [mrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mrc_pkg::COUNT_W-1:0]     inside_count,
  output logic [mrc_pkg::COUNT_W-1:0]     samples_done
);
  import mrc_pkg::*;

  logic [STATE_W-1:0]  rng_seed;
  logic [STREAM_W-1:0] x_stream;
  logic [STREAM_W-1:0] y_stream;
  logic [WORD_W-1:0]   circle_radius_units;
  logic [COUNT_W-1:0]  sample_count;

  logic [COUNT_W-1:0]  sample_index;
  logic [COUNT_W-1:0]  hit_count;

  logic [PIPE_DEPTH-1:0] vld;
  step_flags_t           flags [PIPE_DEPTH];
  logic [PIPE_DEPTH-1:0] stage_en;
  logic [PIPE_DEPTH-1:0] stage_adv;
  logic                  out_ready;

  logic [COUNT_W-1:0] idx_sel;
  logic               take;
  logic [COUNT_W-1:0] idx_next;
  logic               done;
  logic [COUNT_W-1:0] hit_sel;
  logic [COUNT_W-1:0] hit_next;

  pcg_ctl_t          pcg_ctl;
  geo_ctl_t          geo_ctl;
  logic [WORD_W-1:0] x_word;
  logic [WORD_W-1:0] y_word;
  logic              hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rng_seed            <= SEED_RST;
      x_stream            <= X_STREAM_RST;
      y_stream            <= Y_STREAM_RST;
      circle_radius_units <= RADIUS_RST;
      sample_count        <= SAMPLES_RST;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_RNG_SEED:     rng_seed            <= cfg_data;
        REG_X_STREAM:     x_stream            <= cfg_data[STREAM_W-1:0];
        REG_Y_STREAM:     y_stream            <= cfg_data[STREAM_W-1:0];
        REG_RADIUS:       circle_radius_units <= cfg_data[WORD_W-1:0];
        REG_SAMPLE_COUNT: sample_count        <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables ripple back from the output register
  always_comb begin
    out_ready = !out_valid || !out_stall;
    stage_en[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || out_ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      stage_en[k] = !vld[k] || stage_en[k+1];
    end
    stage_adv[0] = stage_en[0] && in_valid;
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      stage_adv[k] = stage_en[k] && vld[k-1];
    end
  end

  assign in_stall = !stage_en[0];

  // run bookkeeping at the input
  assign idx_sel  = restart ? '0 : sample_index;
  assign take     = idx_sel < sample_count;
  assign idx_next = idx_sel + COUNT_W'(take);
  assign done     = take && (idx_next == sample_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
    end else if (stage_adv[0]) begin
      sample_index <= idx_next;
    end
  end

  // valid bits and word flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (stage_en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (stage_en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      flags[0] <= '{restart: restart, take: take, done: done};
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (stage_en[k]) begin
        flags[k] <= flags[k-1];
      end
    end
  end

  // generator and geometry stage control
  always_comb begin
    pcg_ctl.adv_lo     = stage_adv[1];
    pcg_ctl.restart_lo = flags[0].restart;
    pcg_ctl.take_lo    = flags[0].take;
    pcg_ctl.adv_hi     = stage_adv[2];
    pcg_ctl.restart_hi = flags[1].restart;
    pcg_ctl.take_hi    = flags[1].take;
    pcg_ctl.adv_out    = stage_adv[3];
    geo_ctl.adv_prep   = stage_adv[4];
    geo_ctl.adv_sq     = stage_adv[5];
    geo_ctl.adv_cmp    = stage_adv[6];
  end

  mrc_pcg u_pcg_x (
    .clk        (clk),
    .rst        (rst),
    .pre_rst    (X_PRE_RST),
    .stream_rst (X_STREAM_RST),
    .seed       (rng_seed),
    .stream     (x_stream),
    .ctl        (pcg_ctl),
    .word       (x_word)
  );

  mrc_pcg u_pcg_y (
    .clk        (clk),
    .rst        (rst),
    .pre_rst    (Y_PRE_RST),
    .stream_rst (Y_STREAM_RST),
    .seed       (rng_seed),
    .stream     (y_stream),
    .ctl        (pcg_ctl),
    .word       (y_word)
  );

  mrc_region u_region (
    .clk    (clk),
    .x      (x_word),
    .y      (y_word),
    .radius (circle_radius_units),
    .ctl    (geo_ctl),
    .hit    (hit)
  );

  // hit count and output register
  assign hit_sel  = flags[PIPE_DEPTH-1].restart ? '0 : hit_count;
  assign hit_next = hit_sel + COUNT_W'(flags[PIPE_DEPTH-1].take && hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count <= '0;
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= vld[PIPE_DEPTH-1] && flags[PIPE_DEPTH-1].done;
      if (vld[PIPE_DEPTH-1]) begin
        hit_count <= hit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && vld[PIPE_DEPTH-1] && flags[PIPE_DEPTH-1].done) begin
      inside_count <= hit_next;
      samples_done <= sample_count;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mrc_pcg.sv =====
// one pcg32 generator: low-half step, high-half step and output permutation
`default_nettype none

module mrc_pcg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [mrc_pkg::STATE_W-1:0]  pre_rst,
  input  logic [mrc_pkg::STREAM_W-1:0] stream_rst,
  input  logic [mrc_pkg::STATE_W-1:0]  seed,
  input  logic [mrc_pkg::STREAM_W-1:0] stream,
  input  mrc_pkg::pcg_ctl_t            ctl,
  output logic [mrc_pkg::WORD_W-1:0]   word
);
  import mrc_pkg::*;

  logic [WORD_W-1:0]  inc_lo;
  logic [WORD_W-1:0]  inc_hi;
  logic [STATE_W-1:0] pre;
  logic [WORD_W-1:0]  lo_sel;
  logic [WORD_W-1:0]  lo_inc;
  logic [STATE_W-1:0] lo_prod;
  logic [WORD_W-1:0]  lo_cross;
  logic [WORD_W-1:0]  hi_sel;
  logic [WORD_W-1:0]  hi_inc;
  logic [WORD_W-1:0]  hi_step;

  logic [WORD_W-1:0]  state_lo;
  logic [WORD_W-1:0]  inc_lo_pend;
  logic [WORD_W-1:0]  carry_hi;
  logic [WORD_W-1:0]  cross_hi;
  logic [WORD_W-1:0]  state_hi;
  logic [WORD_W-1:0]  inc_hi_pend;
  logic [WORD_W-1:0]  lo_cur;

  // increment and reseed pre-state from the live registers
  assign inc_lo = {stream[30:0], 1'b1};
  assign inc_hi = stream[62:31];
  assign pre    = seed + {stream, 1'b1};

  // the state register trails by one step; the increment owed to that step
  // is the one in force at the draw or reseed that left it there
  assign lo_inc = ctl.restart_lo ? inc_lo : inc_lo_pend;
  assign hi_inc = ctl.restart_hi ? inc_hi : inc_hi_pend;

  // low half: full 32x32 product gives the new low word and its carry
  assign lo_sel   = ctl.restart_lo ? pre[31:0] : state_lo;
  assign lo_prod  = STATE_W'(lo_sel) * STATE_W'(MULT_LO) + STATE_W'(lo_inc);
  assign lo_cross = lo_sel * MULT_HI;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_lo <= pre_rst[31:0];
    end else if (ctl.adv_lo) begin
      state_lo <= ctl.take_lo ? lo_prod[31:0] : lo_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inc_lo_pend <= {stream_rst[30:0], 1'b1};
    end else if (ctl.adv_lo && (ctl.take_lo || ctl.restart_lo)) begin
      inc_lo_pend <= inc_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_lo) begin
      carry_hi <= lo_prod[63:32];
      cross_hi <= lo_cross;
    end
  end

  // high half: stepped in the stage that follows the low half
  assign hi_sel  = ctl.restart_hi ? pre[63:32] : state_hi;
  assign hi_step = carry_hi + cross_hi + hi_inc + hi_sel * MULT_LO;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_hi <= pre_rst[63:32];
    end else if (ctl.adv_hi) begin
      state_hi <= ctl.take_hi ? hi_step : hi_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inc_hi_pend <= stream_rst[62:31];
    end else if (ctl.adv_hi && (ctl.take_hi || ctl.restart_hi)) begin
      inc_hi_pend <= inc_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_hi) begin
      lo_cur <= state_lo;
    end
  end

  // output permutation of the freshly stepped state
  always_ff @(posedge clk) begin
    if (ctl.adv_out) begin
      word <= xsh_rr({state_hi, lo_cur});
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mrc_region.sv =====
// region test: distances, exact squares and the two comparisons
`default_nettype none

module mrc_region (
  input  logic                       clk,
  input  logic [mrc_pkg::WORD_W-1:0] x,
  input  logic [mrc_pkg::WORD_W-1:0] y,
  input  logic [mrc_pkg::WORD_W-1:0] radius,
  input  mrc_pkg::geo_ctl_t          ctl,
  output logic                       hit
);
  import mrc_pkg::*;

  logic [WORD_W-1:0]  x_p;
  logic [WORD_W-1:0]  y_p;
  logic [WORD_W-1:0]  dx;
  logic [WORD_W-1:0]  dy;
  logic [STATE_W-1:0] dx_sq;
  logic [STATE_W-1:0] dy_sq;
  logic [STATE_W-1:0] x_sq;
  logic [STATE_W-1:0] y_sq;
  logic [STATE_W-1:0] r_sq;
  logic [STATE_W:0]   d_sum;
  logic [STATE_W:0]   p_sum;
  logic               in_circle;
  logic               outside_big;

  // absolute offsets from the circle centre
  always_ff @(posedge clk) begin
    if (ctl.adv_prep) begin
      x_p <= x;
      y_p <= y;
      dx  <= (radius > x) ? radius - x : x - radius;
      dy  <= (radius > y) ? radius - y : y - radius;
    end
  end

  // exact squares
  always_ff @(posedge clk) begin
    if (ctl.adv_sq) begin
      dx_sq <= STATE_W'(dx) * STATE_W'(dx);
      dy_sq <= STATE_W'(dy) * STATE_W'(dy);
      x_sq  <= STATE_W'(x_p) * STATE_W'(x_p);
      y_sq  <= STATE_W'(y_p) * STATE_W'(y_p);
      r_sq  <= STATE_W'(radius) * STATE_W'(radius);
    end
  end

  // inside the small circle and outside the big one
  assign d_sum       = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign p_sum       = {1'b0, x_sq} + {1'b0, y_sq};
  assign in_circle   = d_sum < {1'b0, r_sq};
  assign outside_big = {1'b0, p_sum} >= {r_sq, 2'b00};

  always_ff @(posedge clk) begin
    if (ctl.adv_cmp) begin
      hit <= in_circle && outside_big;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mrc_checker.sv =====
// port-level checks of the region counter and their binding
`default_nettype none

module mrc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mrc_pkg::COUNT_W-1:0] inside_count,
  input logic [mrc_pkg::COUNT_W-1:0] samples_done
);
  import mrc_pkg::*;

  // a held word keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inside_count) && $stable(samples_done))
    else $error("held result word changed");

  // hits never exceed samples
  a_hits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inside_count <= samples_done)
    else $error("inside count above sample count");

  // a run with no samples gives no word
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> samples_done != '0)
    else $error("result word with zero samples");

  // input side only stalls when the output is blocked
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output is free");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind monte_carlo_region_counter mrc_checker u_mrc_checker (.*);

`default_nettype wire
